@@ rtl/vgbf_pkg.sv @@
`timescale 1ns / 1ps

package vgbf_pkg;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_NYZ,
        ST_NTOT,
        ST_DISPATCH,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FMUL1,
        ST_FMUL2,
        ST_FILL,
        ST_SCAN,
        ST_E_RD,
        ST_E_MX,
        ST_E_AX,
        ST_E_MY,
        ST_E_AY,
        ST_E_MZ,
        ST_E_AZ,
        ST_OUT
    } state_t;

    localparam logic [1:0] REQ_FILL    = 2'd0;
    localparam logic [1:0] REQ_COUNT   = 2'd1;
    localparam logic [1:0] REQ_EXTRACT = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] CFG_RESOLUTION = 3'd3;
    localparam logic [2:0] CFG_CELLS_X    = 3'd4;
    localparam logic [2:0] CFG_CELLS_Y    = 3'd5;
    localparam logic [2:0] CFG_CELLS_Z    = 3'd6;
    localparam logic [2:0] CFG_DEFAULT    = 3'd7;

    // Division jobs: six box bounds, then the two steps of splitting a start index.
    localparam logic [2:0] DSEL_X0    = 3'd0;
    localparam logic [2:0] DSEL_Y0    = 3'd1;
    localparam logic [2:0] DSEL_Z0    = 3'd2;
    localparam logic [2:0] DSEL_X1    = 3'd3;
    localparam logic [2:0] DSEL_Y1    = 3'd4;
    localparam logic [2:0] DSEL_Z1    = 3'd5;
    localparam logic [2:0] DSEL_START = 3'd6;
    localparam logic [2:0] DSEL_REM   = 3'd7;

    localparam logic [15:0] SCAN_DONE   = 16'h8000;
    localparam logic [30:0] RES_RESET   = 31'd65536;
    localparam logic [5:0]  CELLS_RESET = 6'd32;

    localparam int DIV_DW = 34;
    localparam int DIV_SW = 32;
    localparam int DIV_CW = $clog2(DIV_DW + 1);

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic [DIV_SW-1:0] remainder;
    } div_rsp_t;

endpackage

@@ rtl/vgbf_div.sv @@
`timescale 1ns / 1ps

module vgbf_div import vgbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_SW-1:0] rem_reg;
    logic [DIV_SW-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_SW:0]   shifted;
    logic [DIV_SW:0]   diff;
    logic              ge;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_DW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_SW-1:0] : shifted[DIV_SW-1:0];
            quo_reg <= {quo_reg[DIV_DW-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ rtl/vgbf_mem.sv @@
`timescale 1ns / 1ps

module vgbf_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/voxel_grid_box_fill_extract.sv @@
`timescale 1ns / 1ps

// Voxel grid with box fill, value count, chunked extraction and clear.
// Requests enter on in_valid/in_stall; one request is taken only when the
// block is idle, and in_stall stays high while a request is in progress.
// Results leave on out_valid/out_stall from an output register; a stalled
// result holds, and the sequencer waits on it before producing the next one.
// Configuration writes use cfg_valid/cfg_ready; cfg_ready is always high.
// Fill and clear give no result, count gives one, extract gives one result
// per matching cell (up to CHUNK_MAX) or a single empty one, last on the end.
// Request time is set by the iterative divider, used once per box bound, and
// by the single cell memory port, one cell per cycle.
// After reset the block sweeps zero into every cell, GRID_X*GRID_Y*GRID_Z
// cells (32768 by default), and holds in_stall high until done.
module voxel_grid_box_fill_extract import vgbf_pkg::*; #(
    parameter int GRID_X    = 32,
    parameter int GRID_Y    = 32,
    parameter int GRID_Z    = 32,
    parameter int CHUNK_MAX = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] corner_x,
    input  logic signed [31:0] corner_y,
    input  logic signed [31:0] corner_z,
    input  logic [30:0]        extent_x,
    input  logic [30:0]        extent_y,
    input  logic [30:0]        extent_z,
    input  logic [7:0]         cell_value,
    input  logic [14:0]        start_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        match_count,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_z,
    output logic               found,
    output logic [15:0]        next_index,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int GMAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int GMAX    = (GMAX_XY > GRID_Z) ? GMAX_XY : GRID_Z;
    localparam int CW      = $clog2(GMAX + 1);
    localparam int DEPTH   = GRID_X * GRID_Y * GRID_Z;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW      = $clog2(DEPTH + 1);
    localparam int IW      = (NW > 16) ? NW : 16;
    localparam int HW      = $clog2(CHUNK_MAX + 1);
    localparam int HAW     = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
    localparam int PW      = 32 + CW;
    localparam int SW      = PW + 2;
    localparam logic signed [SW-1:0] SMAX = {{(SW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-31){1'b1}}, {31{1'b0}}};

    state_t state_reg, state_next;

    // Configuration registers.
    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [30:0]        res_reg;
    logic [5:0]         cells_x_reg, cells_y_reg, cells_z_reg;
    logic [7:0]         dflt_reg;

    // Request registers.
    logic [1:0]         req_reg;
    logic signed [31:0] cor_x_reg, cor_y_reg, cor_z_reg;
    logic [30:0]        ext_x_reg, ext_y_reg, ext_z_reg;
    logic [7:0]         val_reg;
    logic [14:0]        start_reg;

    // Sequencer datapath.
    logic [CW-1:0]   nx, ny, nz;
    logic [30:0]     res_use;
    logic [IW-1:0]   nyz_reg, n_reg, t_reg;
    logic [IW-1:0]   addr_reg, row_reg, plane_reg;
    logic [CW-1:0]   lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;
    logic [CW-1:0]   sx_reg, sy_reg, sz_reg;
    logic [IW-1:0]   scan_idx_reg;
    logic            issue_on_reg;
    logic            chk_valid_reg;
    logic [IW-1:0]   chk_idx_reg;
    logic [CW-1:0]   chk_x_reg, chk_y_reg, chk_z_reg;
    logic [IW-1:0]   cnt_reg;
    logic [HW-1:0]   hit_cnt_reg, emit_idx_reg;
    logic [IW-1:0]   next_reg;
    logic [2:0]      div_sel_reg;
    logic [IW-1:0]   rem_reg;
    logic [AW-1:0]   clr_idx_reg;
    logic [7:0]      fill_val_reg;
    logic [PW-1:0]   prod_reg;
    logic [3*CW-1:0] hits_mem [CHUNK_MAX];
    logic [3*CW-1:0] hit_rd_reg;

    // Output register.
    logic [15:0]        out_count_reg;
    logic signed [31:0] out_wx_reg, out_wy_reg, out_wz_reg;
    logic               out_found_reg;
    logic [15:0]        out_next_reg;
    logic               out_last_reg;

    // Shared units.
    logic [31:0]   mul_a;
    logic [CW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    logic in_acc, out_acc;
    logic hit, full, issue, scan_end, box_empty;
    logic z_more, y_more, x_more;
    logic signed [31:0] c_sel, o_sel;
    logic [30:0]        e_sel;
    logic [CW-1:0]      lim_sel;
    logic signed [DIV_DW-1:0] dpt;
    logic [CW-1:0]      cell_q;
    logic signed [31:0] org_e;
    logic signed [SW-1:0] wsum;
    logic signed [31:0] wsat;
    logic [CW-1:0]      hx, hy, hz;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        nx = (cells_x_reg == 6'd0) ? CW'(1) :
             (int'(cells_x_reg) > GRID_X) ? CW'(GRID_X) : CW'(cells_x_reg);
        ny = (cells_y_reg == 6'd0) ? CW'(1) :
             (int'(cells_y_reg) > GRID_Y) ? CW'(GRID_Y) : CW'(cells_y_reg);
        nz = (cells_z_reg == 6'd0) ? CW'(1) :
             (int'(cells_z_reg) > GRID_Z) ? CW'(GRID_Z) : CW'(cells_z_reg);
        res_use = (res_reg == 31'd0) ? 31'd1 : res_reg;
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign {hx, hy, hz} = hit_rd_reg;

    // Box bound operands for the divider; a point below the origin maps to cell 0.
    always_comb
    begin
        case (div_sel_reg)
            DSEL_X0, DSEL_X1:
            begin
                c_sel = cor_x_reg; o_sel = origin_x_reg; e_sel = ext_x_reg; lim_sel = nx;
            end
            DSEL_Y0, DSEL_Y1:
            begin
                c_sel = cor_y_reg; o_sel = origin_y_reg; e_sel = ext_y_reg; lim_sel = ny;
            end
            default:
            begin
                c_sel = cor_z_reg; o_sel = origin_z_reg; e_sel = ext_z_reg; lim_sel = nz;
            end
        endcase
        dpt = {{2{c_sel[31]}}, c_sel}
            + ((div_sel_reg >= DSEL_X1) ? {3'b000, e_sel} : DIV_DW'(0))
            - {{2{o_sel[31]}}, o_sel};
        cell_q = (div_rsp.quotient > DIV_DW'(lim_sel)) ? lim_sel
                                                       : CW'(div_rsp.quotient);
    end

    always_comb
    begin
        hit       = (state_reg == ST_SCAN) && chk_valid_reg && (mem_rdata == val_reg);
        full      = hit && (req_reg == REQ_EXTRACT)
                    && (hit_cnt_reg == HW'(CHUNK_MAX - 1));
        issue     = issue_on_reg && !full;
        scan_end  = !issue_on_reg && !chk_valid_reg;
        box_empty = (lo_x_reg >= hi_x_reg) || (lo_y_reg >= hi_y_reg)
                    || (lo_z_reg >= hi_z_reg);
        z_more    = ((CW+1)'(sz_reg) + (CW+1)'(1)) < (CW+1)'(hi_z_reg);
        y_more    = ((CW+1)'(sy_reg) + (CW+1)'(1)) < (CW+1)'(hi_y_reg);
        x_more    = ((CW+1)'(sx_reg) + (CW+1)'(1)) < (CW+1)'(hi_x_reg);
    end

    // World coordinate: origin plus the registered product, saturated.
    always_comb
    begin
        case (state_reg)
            ST_E_AX: org_e = origin_x_reg;
            ST_E_AY: org_e = origin_y_reg;
            default: org_e = origin_z_reg;
        endcase
        wsum = {{(SW-32){org_e[31]}}, org_e} + {2'b00, prod_reg};
        if (wsum > SMAX)
        begin
            wsat = 32'sh7FFFFFFF;
        end
        else if (wsum < SMIN)
        begin
            wsat = 32'sh80000000;
        end
        else
        begin
            wsat = wsum[31:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (clr_idx_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (req_type == REQ_CLEAR) ? ST_CLR : ST_NYZ;
                end
            end
            ST_NYZ:      state_next = ST_NTOT;
            ST_NTOT:     state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                unique case (req_reg)
                    REQ_FILL:  state_next = ST_DIV_GO;
                    REQ_COUNT: state_next = ST_SCAN;
                    default:
                    begin
                        state_next = (IW'(start_reg) >= n_reg) ? ST_OUT : ST_DIV_GO;
                    end
                endcase
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_sel_reg == DSEL_Z1)
                    begin
                        state_next = ST_FMUL1;
                    end
                    else if (div_sel_reg == DSEL_REM)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_FMUL1:    state_next = box_empty ? ST_IDLE : ST_FMUL2;
            ST_FMUL2:    state_next = ST_FILL;
            ST_FILL:
            begin
                if (!z_more && !y_more && !x_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (full)
                begin
                    state_next = ST_E_RD;
                end
                else if (scan_end)
                begin
                    if (req_reg == REQ_COUNT || hit_cnt_reg == HW'(0))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_E_RD:     state_next = ST_E_MX;
            ST_E_MX:     state_next = ST_E_AX;
            ST_E_AX:     state_next = ST_E_MY;
            ST_E_MY:     state_next = ST_E_AY;
            ST_E_AY:     state_next = ST_E_MZ;
            ST_E_MZ:     state_next = ST_E_AZ;
            ST_E_AZ:     state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_acc)
                begin
                    state_next = out_last_reg ? ST_IDLE : ST_E_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshakes, memory write port and shared unit operands.
    always_comb
    begin
        in_stall         = (state_reg != ST_IDLE);
        out_valid        = (state_reg == ST_OUT);
        mem_we           = 1'b0;
        mem_waddr        = clr_idx_reg;
        mem_wdata        = fill_val_reg;
        mul_a            = 32'(ny);
        mul_b            = nz;
        div_req.start    = (state_reg == ST_DIV_GO);
        div_req.dividend = dpt[DIV_DW-1] ? DIV_DW'(0) : dpt;
        div_req.divisor  = {1'b0, res_use};
        if (div_sel_reg == DSEL_START)
        begin
            div_req.dividend = DIV_DW'(start_reg);
            div_req.divisor  = DIV_SW'(nyz_reg);
        end
        else if (div_sel_reg == DSEL_REM)
        begin
            div_req.dividend = DIV_DW'(rem_reg);
            div_req.divisor  = DIV_SW'(nz);
        end
        unique case (state_reg)
            ST_CLR:
            begin
                mem_we = 1'b1;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg[AW-1:0];
                mem_wdata = val_reg;
            end
            ST_NTOT:
            begin
                mul_a = 32'(nyz_reg);
                mul_b = nx;
            end
            ST_FMUL1:
            begin
                mul_a = 32'(lo_x_reg);
                mul_b = ny;
            end
            ST_FMUL2:
            begin
                mul_a = 32'(t_reg);
                mul_b = nz;
            end
            ST_E_MX:
            begin
                mul_a = {1'b0, res_use};
                mul_b = hx;
            end
            ST_E_MY:
            begin
                mul_a = {1'b0, res_use};
                mul_b = hy;
            end
            ST_E_MZ:
            begin
                mul_a = {1'b0, res_use};
                mul_b = hz;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            res_reg      <= RES_RESET;
            cells_x_reg  <= CELLS_RESET;
            cells_y_reg  <= CELLS_RESET;
            cells_z_reg  <= CELLS_RESET;
            dflt_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y:   origin_y_reg <= cfg_data;
                CFG_ORIGIN_Z:   origin_z_reg <= cfg_data;
                CFG_RESOLUTION: res_reg      <= cfg_data[30:0];
                CFG_CELLS_X:    cells_x_reg  <= cfg_data[5:0];
                CFG_CELLS_Y:    cells_y_reg  <= cfg_data[5:0];
                CFG_CELLS_Z:    cells_z_reg  <= cfg_data[5:0];
                CFG_DEFAULT:    dflt_reg     <= cfg_data[7:0];
                default:        dflt_reg     <= dflt_reg;
            endcase
        end
    end

    // Control counters and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            fill_val_reg  <= '0;
            issue_on_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            emit_idx_reg  <= '0;
            div_sel_reg   <= DSEL_X0;
        end
        else
        begin
            case (state_reg)
                ST_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    clr_idx_reg  <= '0;
                    fill_val_reg <= dflt_reg;
                end
                ST_DISPATCH:
                begin
                    div_sel_reg   <= (req_reg == REQ_FILL) ? DSEL_X0 : DSEL_START;
                    issue_on_reg  <= 1'b1;
                    chk_valid_reg <= 1'b0;
                    hit_cnt_reg   <= '0;
                    emit_idx_reg  <= '0;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        div_sel_reg <= div_sel_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    chk_valid_reg <= issue;
                    if (issue && scan_idx_reg == n_reg - 1'b1)
                    begin
                        issue_on_reg <= 1'b0;
                    end
                    if (full)
                    begin
                        issue_on_reg <= 1'b0;
                    end
                    if (hit && req_reg == REQ_EXTRACT)
                    begin
                        hit_cnt_reg <= hit_cnt_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        emit_idx_reg <= emit_idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    clr_idx_reg <= clr_idx_reg;
                end
            endcase
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg   <= req_type;
            cor_x_reg <= corner_x;
            cor_y_reg <= corner_y;
            cor_z_reg <= corner_z;
            ext_x_reg <= extent_x;
            ext_y_reg <= extent_y;
            ext_z_reg <= extent_z;
            val_reg   <= cell_value;
            start_reg <= start_index;
        end

        hit_rd_reg <= hits_mem[emit_idx_reg[HAW-1:0]];
        if (hit && req_reg == REQ_EXTRACT)
        begin
            hits_mem[hit_cnt_reg[HAW-1:0]] <= {chk_x_reg, chk_y_reg, chk_z_reg};
        end

        case (state_reg)
            ST_NYZ:
            begin
                nyz_reg <= IW'(mul_p);
            end
            ST_NTOT:
            begin
                n_reg <= IW'(mul_p);
            end
            ST_DISPATCH:
            begin
                cnt_reg      <= '0;
                scan_idx_reg <= IW'(start_reg);
                sx_reg       <= '0;
                sy_reg       <= '0;
                sz_reg       <= '0;
                if (req_reg == REQ_COUNT)
                begin
                    scan_idx_reg <= '0;
                end
                // Extract with a start past the grid gives one empty result.
                out_count_reg <= '0;
                out_wx_reg    <= '0;
                out_wy_reg    <= '0;
                out_wz_reg    <= '0;
                out_found_reg <= 1'b0;
                out_next_reg  <= SCAN_DONE;
                out_last_reg  <= 1'b1;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (div_sel_reg)
                        DSEL_X0:    lo_x_reg <= cell_q;
                        DSEL_Y0:    lo_y_reg <= cell_q;
                        DSEL_Z0:    lo_z_reg <= cell_q;
                        DSEL_X1:    hi_x_reg <= cell_q;
                        DSEL_Y1:    hi_y_reg <= cell_q;
                        DSEL_Z1:    hi_z_reg <= cell_q;
                        DSEL_START:
                        begin
                            sx_reg  <= CW'(div_rsp.quotient);
                            rem_reg <= IW'(div_rsp.remainder);
                        end
                        default:
                        begin
                            sy_reg <= CW'(div_rsp.quotient);
                            sz_reg <= CW'(div_rsp.remainder);
                        end
                    endcase
                end
            end
            ST_FMUL1:
            begin
                t_reg  <= IW'(mul_p) + IW'(lo_y_reg);
                sx_reg <= lo_x_reg;
                sy_reg <= lo_y_reg;
                sz_reg <= lo_z_reg;
            end
            ST_FMUL2:
            begin
                addr_reg  <= IW'(mul_p) + IW'(lo_z_reg);
                row_reg   <= IW'(mul_p) + IW'(lo_z_reg);
                plane_reg <= IW'(mul_p) + IW'(lo_z_reg);
            end
            ST_FILL:
            begin
                // Walk the box with z innermost; row and plane bases track the address.
                if (z_more)
                begin
                    sz_reg   <= sz_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                end
                else if (y_more)
                begin
                    sy_reg   <= sy_reg + 1'b1;
                    sz_reg   <= lo_z_reg;
                    row_reg  <= row_reg + IW'(nz);
                    addr_reg <= row_reg + IW'(nz);
                end
                else if (x_more)
                begin
                    sx_reg    <= sx_reg + 1'b1;
                    sy_reg    <= lo_y_reg;
                    sz_reg    <= lo_z_reg;
                    plane_reg <= plane_reg + nyz_reg;
                    row_reg   <= plane_reg + nyz_reg;
                    addr_reg  <= plane_reg + nyz_reg;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    chk_idx_reg  <= scan_idx_reg;
                    chk_x_reg    <= sx_reg;
                    chk_y_reg    <= sy_reg;
                    chk_z_reg    <= sz_reg;
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (sz_reg + 1'b1 == nz)
                    begin
                        sz_reg <= '0;
                        if (sy_reg + 1'b1 == ny)
                        begin
                            sy_reg <= '0;
                            sx_reg <= sx_reg + 1'b1;
                        end
                        else
                        begin
                            sy_reg <= sy_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sz_reg <= sz_reg + 1'b1;
                    end
                end
                if (hit)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (full)
                begin
                    next_reg <= (chk_idx_reg + 1'b1 < n_reg) ? chk_idx_reg + 1'b1
                                                             : IW'(SCAN_DONE);
                end
                else if (scan_end)
                begin
                    next_reg      <= IW'(SCAN_DONE);
                    out_count_reg <= cnt_reg[15:0];
                    out_next_reg  <= (req_reg == REQ_COUNT) ? 16'd0 : SCAN_DONE;
                    out_found_reg <= 1'b0;
                    out_last_reg  <= 1'b1;
                end
            end
            ST_E_MX, ST_E_MY, ST_E_MZ:
            begin
                prod_reg <= mul_p;
            end
            ST_E_AX:
            begin
                out_wx_reg <= wsat;
            end
            ST_E_AY:
            begin
                out_wy_reg <= wsat;
            end
            ST_E_AZ:
            begin
                out_wz_reg    <= wsat;
                out_count_reg <= '0;
                out_found_reg <= 1'b1;
                out_next_reg  <= next_reg[15:0];
                out_last_reg  <= (emit_idx_reg + 1'b1 == hit_cnt_reg);
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    vgbf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    vgbf_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign match_count = out_count_reg;
    assign world_x     = out_wx_reg;
    assign world_y     = out_wy_reg;
    assign world_z     = out_wz_reg;
    assign found       = out_found_reg;
    assign next_index  = out_next_reg;
    assign last        = out_last_reg;

endmodule

@@ test/tb_voxel_grid_box_fill_extract.sv @@
`timescale 1ns / 1ps

module tb_voxel_grid_box_fill_extract;
    import vgbf_pkg::*;

    localparam int GRID      = 32;
    localparam int CELLS_ALL = GRID * GRID * GRID;
    localparam int CHUNK     = 64;
    localparam int HANG_LIMIT = 150000;

    typedef struct {
        bit [1:0]         kind;
        bit signed [31:0] cx, cy, cz;
        bit [30:0]        ex, ey, ez;
        bit [7:0]         value;
        bit [14:0]        start;
    } request_t;

    typedef struct {
        bit [15:0]        match_count;
        bit signed [31:0] wx, wy, wz;
        bit               found;
        bit [15:0]        next;
        bit               last;
    } result_t;

    class grid_scoreboard;
        bit [7:0]  cells[CELLS_ALL];
        int        org[3];
        bit [30:0] res;
        bit [5:0]  dim[3];
        bit [7:0]  dflt;
        result_t   pending[$];
        int        errors;

        function new();
            foreach (cells[i]) cells[i] = 8'd0;
            foreach (org[a]) org[a] = 0;
            foreach (dim[a]) dim[a] = CELLS_RESET;
            res = RES_RESET;
            dflt = 8'd0;
            errors = 0;
        endfunction

        function void write_reg(bit [2:0] idx, bit [31:0] data);
            case (idx)
                CFG_ORIGIN_X:   org[0] = data;
                CFG_ORIGIN_Y:   org[1] = data;
                CFG_ORIGIN_Z:   org[2] = data;
                CFG_RESOLUTION: res = data[30:0];
                CFG_CELLS_X:    dim[0] = data[5:0];
                CFG_CELLS_Y:    dim[1] = data[5:0];
                CFG_CELLS_Z:    dim[2] = data[5:0];
                CFG_DEFAULT:    dflt = data[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned used(int a);
            if (dim[a] == 0) return 1;
            if (dim[a] > GRID) return GRID;
            return dim[a];
        endfunction

        function longint step();
            return (res == 0) ? 64'sd1 : longint'(res);
        endfunction

        // Floor division toward minus infinity, then clip to [0, cells].
        function int unsigned cell_of(longint p, int a);
            longint d, q;
            d = p - longint'(org[a]);
            q = d / step();
            if ((d % step()) != 0 && d < 0) q--;
            if (q < 0) return 0;
            if (q > used(a)) return used(a);
            return q;
        endfunction

        function bit signed [31:0] world(int a, int unsigned idx);
            longint w;
            w = longint'(org[a]) + step() * longint'(idx);
            if (w > 64'sd2147483647) w = 64'sd2147483647;
            if (w < -64'sd2147483648) w = -64'sd2147483648;
            return w[31:0];
        endfunction

        function void note_request(request_t rq);
            int unsigned nx, ny, nz, n, cnt, nxt, idx, rem;
            int unsigned lo[3], hi[3];
            int unsigned hits[$];
            result_t r;
            nx = used(0);
            ny = used(1);
            nz = used(2);
            n = nx * ny * nz;
            r = '{default: 0};
            case (rq.kind)
                REQ_FILL:
                begin
                    lo[0] = cell_of(rq.cx, 0);
                    lo[1] = cell_of(rq.cy, 1);
                    lo[2] = cell_of(rq.cz, 2);
                    hi[0] = cell_of(longint'(rq.cx) + longint'(rq.ex), 0);
                    hi[1] = cell_of(longint'(rq.cy) + longint'(rq.ey), 1);
                    hi[2] = cell_of(longint'(rq.cz) + longint'(rq.ez), 2);
                    for (int unsigned i = lo[0]; i < hi[0]; i++)
                        for (int unsigned j = lo[1]; j < hi[1]; j++)
                            for (int unsigned k = lo[2]; k < hi[2]; k++)
                                cells[(i * ny + j) * nz + k] = rq.value;
                end
                REQ_COUNT:
                begin
                    cnt = 0;
                    for (int unsigned i = 0; i < n; i++)
                        if (cells[i] == rq.value) cnt++;
                    r.match_count = cnt;
                    r.last = 1'b1;
                    pending.push_back(r);
                end
                REQ_EXTRACT:
                begin
                    nxt = SCAN_DONE;
                    for (int unsigned i = rq.start; i < n; i++)
                    begin
                        if (cells[i] == rq.value)
                        begin
                            hits.push_back(i);
                            if (hits.size() == CHUNK)
                            begin
                                if (i + 1 < n) nxt = i + 1;
                                break;
                            end
                        end
                    end
                    if (hits.size() == 0)
                    begin
                        r.next = SCAN_DONE;
                        r.last = 1'b1;
                        pending.push_back(r);
                    end
                    foreach (hits[h])
                    begin
                        idx = hits[h];
                        rem = idx % (ny * nz);
                        r.wx = world(0, idx / (ny * nz));
                        r.wy = world(1, rem / nz);
                        r.wz = world(2, rem % nz);
                        r.found = 1'b1;
                        r.next = nxt;
                        r.last = (h == hits.size() - 1);
                        pending.push_back(r);
                    end
                end
                REQ_CLEAR:
                    foreach (cells[i]) cells[i] = dflt;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result at %0t", $time);
                return;
            end
            want = pending.pop_front();
            if (got.match_count != want.match_count || got.wx != want.wx ||
                got.wy != want.wy || got.wz != want.wz || got.found != want.found ||
                got.next != want.next || got.last != want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at %0t: expected cnt=%0d w=(%0d,%0d,%0d) f=%0d nx=%0d l=%0d, got cnt=%0d w=(%0d,%0d,%0d) f=%0d nx=%0d l=%0d",
                        $time, want.match_count, want.wx, want.wy, want.wz, want.found,
                        want.next, want.last, got.match_count, got.wx, got.wy, got.wz,
                        got.found, got.next, got.last);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = '0;
    logic signed [31:0] corner_x = '0, corner_y = '0, corner_z = '0;
    logic [30:0]        extent_x = '0, extent_y = '0, extent_z = '0;
    logic [7:0]         cell_value = '0;
    logic [14:0]        start_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        match_count;
    logic signed [31:0] world_x, world_y, world_z;
    logic               found;
    logic [15:0]        next_index;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    grid_scoreboard sb = new();
    bit quiet = 1'b0;
    int clears_left = 6;
    int idle_cycles = 0;

    voxel_grid_box_fill_extract u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 34);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{match_count, world_x, world_y, world_z, found, next_index, last});
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == HANG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit [30:0] sat_extent(longint v);
        if (v > 64'sd2147483647) return 31'h7fffffff;
        return v[30:0];
    endfunction

    task automatic send_request(request_t rq);
        while (!quiet && $urandom_range(99) < 34)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_type = rq.kind;
        corner_x = rq.cx; corner_y = rq.cy; corner_z = rq.cz;
        extent_x = rq.ex; extent_y = rq.ey; extent_z = rq.ez;
        cell_value = rq.value;
        start_index = rq.start;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_request(rq);
        @(negedge clk);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [31:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Fill requests give no result, so idle means nothing pending and no stall.
    task automatic wait_idle();
        in_valid = 1'b0;
        repeat (4) @(posedge clk);
        while (sb.pending.size() != 0 || in_stall) @(posedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_grid(bit [31:0] ox, bit [31:0] oy, bit [31:0] oz, bit [31:0] rs,
                            bit [31:0] nx, bit [31:0] ny, bit [31:0] nz, bit [31:0] dv);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_RESOLUTION, rs);
        write_reg(CFG_CELLS_X, nx);
        write_reg(CFG_CELLS_Y, ny);
        write_reg(CFG_CELLS_Z, nz);
        write_reg(CFG_DEFAULT, dv);
    endtask

    function automatic request_t make_request(bit [1:0] kind, longint x, longint y, longint z,
                                              longint ex, longint ey, longint ez,
                                              bit [7:0] value, bit [14:0] start);
        request_t rq;
        rq.kind = kind;
        rq.cx = sat32(x); rq.cy = sat32(y); rq.cz = sat32(z);
        rq.ex = sat_extent(ex); rq.ey = sat_extent(ey); rq.ez = sat_extent(ez);
        rq.value = value;
        rq.start = start;
        return rq;
    endfunction

    // A corner lands near a cell boundary of the current grid, sometimes just outside.
    function automatic longint near_corner(int a);
        longint r;
        r = sb.step();
        return longint'(sb.org[a]) + r * (longint'($urandom_range(sb.used(a) + 1)) - 1)
               + ((r > 1) ? longint'($urandom_range(r - 1)) : 0);
    endfunction

    function automatic longint near_extent(int a);
        longint r;
        r = sb.step();
        return r * longint'($urandom_range(sb.used(a)))
               + ((r > 1) ? longint'($urandom_range(r - 1)) : 0);
    endfunction

    task automatic run_random(int count);
        request_t rq;
        int pick, n;
        for (int i = 0; i < count; i++)
        begin
            n = sb.used(0) * sb.used(1) * sb.used(2);
            pick = $urandom_range(99);
            rq = make_request(REQ_FILL, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            if ($urandom_range(3) != 0) rq.value = $urandom_range(3);
            if (pick < 45)
            begin
                if ($urandom_range(4) != 0)
                    rq = make_request(REQ_FILL, near_corner(0), near_corner(1), near_corner(2),
                                      near_extent(0), near_extent(1), near_extent(2),
                                      rq.value, rq.start);
            end
            else if (pick < 65)
                rq.kind = REQ_COUNT;
            else if (pick < 97 || clears_left == 0)
            begin
                rq.kind = REQ_EXTRACT;
                if ($urandom_range(4) != 0) rq.start = $urandom_range(n);
            end
            else
            begin
                rq.kind = REQ_CLEAR;
                clears_left--;
            end
            send_request(rq);
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Full 32-cube grid at reset settings, one cell per 65536 world units.
        send_request(make_request(REQ_FILL, 32'h10000, 32'h20000, 32'h30000,
                                  32'h20000, 32'h20000, 32'h20000, 8'd5, 15'd0));
        send_request(make_request(REQ_FILL, -64'sd2147483648, -64'sd2147483648,
                                  -64'sd2147483648, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 8'd7, 15'd0));
        send_request(make_request(REQ_FILL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 8'd7, 15'd0));
        send_request(make_request(REQ_FILL, 32'h1e8000, 32'h0, -32'sh10000,
                                  32'ha0000, 32'h10000, 32'h30000, 8'd3, 15'd0));
        send_request(make_request(REQ_FILL, 32'h40000, 32'h40000, 32'h40000,
                                  0, 0, 0, 8'd9, 15'd0));
        send_request(make_request(REQ_FILL, -32'sh8000, -32'sh8000, 32'h1f0000,
                                  32'h10000, 32'h18000, 32'h7fffffff, 8'hff, 15'd0));
        send_request(make_request(REQ_COUNT, 0, 0, 0, 0, 0, 0, 8'd5, 15'd0));
        send_request(make_request(REQ_COUNT, 0, 0, 0, 0, 0, 0, 8'd0, 15'd0));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd5, 15'd0));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd0, 15'd0));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd0, 15'd32767));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd200, 15'd32767));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd3, 15'd29000));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'hff, 15'd0));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd0, 15'd32700));
        wait_idle();

        // Small grid with no idling on either side.
        quiet = 1'b1;
        set_grid(0, 0, 0, 32'h10000, 4, 4, 4, 9);
        send_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 8'd0, 15'd0));
        send_request(make_request(REQ_COUNT, 0, 0, 0, 0, 0, 0, 8'd9, 15'd0));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd9, 15'd60));
        send_request(make_request(REQ_EXTRACT, 0, 0, 0, 0, 0, 0, 8'd9, 15'd64));
        run_random(46);
        wait_idle();
        quiet = 1'b0;

        // Extreme origins, finest step; cell counts saturate both ways.
        set_grid(32'h80000000, 32'h7fffffff, 32'd12345, 32'd1, 32'd63, 32'd0, 32'd2, 32'd255);
        run_random(49);
        wait_idle();

        // Zero step counts as the finest step.
        set_grid(32'h7fff0000, -32'sd5, -32'sh8000, 32'd0, 5, 3, 7, 0);
        run_random(49);
        wait_idle();

        // Coarsest step drives world coordinates into saturation.
        set_grid($urandom, $urandom, $urandom, 32'h7fffffff, 2, 6, 5, $urandom);
        run_random(49);
        wait_idle();

        for (int p = 0; p < 2; p++)
        begin
            set_grid($urandom_range(32'h200000) - 32'h100000, $urandom_range(32'h200000) - 32'h100000,
                     $urandom, $urandom_range(1, 32'h100000) | ($urandom & 32'h80000000),
                     {$urandom_range(32'h3ffffff), 6'($urandom_range(1, 6))},
                     {$urandom_range(32'h3ffffff), 6'($urandom_range(1, 6))},
                     {$urandom_range(32'h3ffffff), 6'($urandom_range(1, 6))}, $urandom);
            run_random(49);
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
